>>> design/image_tile_replicator_top_assert.svh
// Assertion macros for the image tile replicator.
`ifndef IMAGE_TILE_REPLICATOR_TOP_ASSERT_SVH
`define IMAGE_TILE_REPLICATOR_TOP_ASSERT_SVH

// Check a consequence in the same cycle.
`define ITR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define ITR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/itr_pkg.sv
// Shared constants and types for the image tile replicator.
`default_nettype none

package itr_pkg;

    localparam int PIX_W     = 32;
    localparam int DIM_W     = 9;
    localparam int POS_W     = 8;
    localparam int ADDR_W    = 2 * POS_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int NUM_W     = DIM_W + 1;
    localparam int STEP_W    = 4;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0]  MAX_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  MAX_HEIGHT = 9'd256;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    localparam logic [OP_W-1:0] OP_LOAD_COL = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ROW = 3'd1;
    localparam logic [OP_W-1:0] OP_TILE_W   = 3'd2;
    localparam logic [OP_W-1:0] OP_TILE_H   = 3'd3;
    localparam logic [OP_W-1:0] OP_OUT_COL  = 3'd4;
    localparam logic [OP_W-1:0] OP_OUT_ROW  = 3'd5;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> design/image_tile_replicator_top.sv
// Image tile replicator: sample store, raster counters and output register.
//
// Outside a configuration write and the rebuild after it, one word per cycle
// is sustained in both directions: a load is accepted every cycle, an emit
// every cycle while the output side drains, and loads still go in while a
// result waits. Samples live in a 64K x 32 synchronous memory with one write
// and one read port; an emit reads it in its accept cycle and the registered
// read data is the result. Modulo and divide are replaced by wrapping phase
// counters. After every configuration write the input stalls while a shared
// restoring divider (10 steps plus a load step per division, six divisions)
// rebuilds the phase counters and tile size from the kept positions; when the
// tile count is zero the rebuild is skipped. The store has no clearing pass;
// unwritten entries read as whatever they hold.
`default_nettype none

`include "image_tile_replicator_top_assert.svh"

module image_tile_replicator_top
    import itr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 req_type,
    input  wire logic [PIX_W-1:0]     pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [PIX_W-1:0]          pixel_out,
    output logic                      last_pixel,
    output logic                      bad_config
);

    logic [DIM_W-1:0]  tile_count_reg, image_width_reg, image_height_reg;
    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  div_num_reg, div_num_next;
    logic [DIM_W-1:0]  div_rem_reg, div_rem_next;
    logic [DIM_W-1:0]  div_den_reg, div_den_next;

    logic [POS_W-1:0]  load_col_reg, load_col_next, load_row_reg, load_row_next;
    logic [POS_W-1:0]  lc_ph_reg, lc_ph_next, lc_q_reg, lc_q_next;
    logic [POS_W-1:0]  lr_ph_reg, lr_ph_next, lr_q_reg, lr_q_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic [POS_W-1:0]  oc_ph_reg, oc_ph_next, or_ph_reg, or_ph_next;
    logic [DIM_W-1:0]  tile_w_reg, tile_w_next, tile_h_reg, tile_h_next;

    logic              out_valid_reg, out_valid_next;
    logic              last_reg, last_next, bad_reg, bad_next;
    logic [PIX_W-1:0]  rd_data_reg;

    logic [PIX_W-1:0]  sample_mem [STORE_DEPTH];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              n_zero, in_fire, out_fire;
    logic [NUM_W-1:0]  trial, rem_wide, num_step, op_num;
    logic [DIM_W-1:0]  op_den;
    logic              trial_ge;
    logic [DIM_W-1:0]  lcol_inc, lrow_inc, ocol_inc, orow_inc;
    logic [DIM_W-1:0]  lc_ph_inc, lr_ph_inc, oc_ph_inc, or_ph_inc;

    assign w_eff = (image_width_reg == '0) ? DIM_W'(1) :
                   ((image_width_reg > MAX_WIDTH) ? MAX_WIDTH : image_width_reg);
    assign h_eff = (image_height_reg == '0) ? DIM_W'(1) :
                   ((image_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : image_height_reg);
    assign n_zero = (tile_count_reg == '0);

    assign in_stall = cfg_we || (state_reg != ST_RUN) ||
                      ((req_type == REQ_EMIT) && out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign out_valid  = out_valid_reg;
    assign pixel_out  = bad_reg ? '0 : rd_data_reg;
    assign last_pixel = last_reg;
    assign bad_config = bad_reg;

    assign trial    = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, div_den_reg});
    assign rem_wide = trial_ge ? (trial - {1'b0, div_den_reg}) : trial;
    assign num_step = {div_num_reg[NUM_W-2:0], trial_ge};

    assign lcol_inc  = {1'b0, load_col_reg} + DIM_W'(1);
    assign lrow_inc  = {1'b0, load_row_reg} + DIM_W'(1);
    assign ocol_inc  = {1'b0, out_col_reg} + DIM_W'(1);
    assign orow_inc  = {1'b0, out_row_reg} + DIM_W'(1);
    assign lc_ph_inc = {1'b0, lc_ph_reg} + DIM_W'(1);
    assign lr_ph_inc = {1'b0, lr_ph_reg} + DIM_W'(1);
    assign oc_ph_inc = {1'b0, oc_ph_reg} + DIM_W'(1);
    assign or_ph_inc = {1'b0, or_ph_reg} + DIM_W'(1);

    always_comb
    begin
        case (op_reg)
            OP_LOAD_COL:
            begin
                op_num = {2'b00, load_col_reg};
                op_den = tile_count_reg;
            end
            OP_LOAD_ROW:
            begin
                op_num = {2'b00, load_row_reg};
                op_den = tile_count_reg;
            end
            OP_TILE_W:
            begin
                op_num = {1'b0, w_eff} + {1'b0, tile_count_reg} - NUM_W'(1);
                op_den = tile_count_reg;
            end
            OP_TILE_H:
            begin
                op_num = {1'b0, h_eff} + {1'b0, tile_count_reg} - NUM_W'(1);
                op_den = tile_count_reg;
            end
            OP_OUT_COL:
            begin
                op_num = {2'b00, out_col_reg};
                op_den = tile_w_reg;
            end
            OP_OUT_ROW:
            begin
                op_num = {2'b00, out_row_reg};
                op_den = tile_h_reg;
            end
            default:
            begin
                op_num = '0;
                op_den = tile_count_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        load_col_next  = load_col_reg;
        load_row_next  = load_row_reg;
        lc_ph_next     = lc_ph_reg;
        lc_q_next      = lc_q_reg;
        lr_ph_next     = lr_ph_reg;
        lr_q_next      = lr_q_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        oc_ph_next     = oc_ph_reg;
        or_ph_next     = or_ph_reg;
        tile_w_next    = tile_w_reg;
        tile_h_next    = tile_h_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = {lr_q_reg, lc_q_reg};
        mem_raddr      = {or_ph_reg, oc_ph_reg};

        if (cfg_we)
        begin
            state_next = ST_DIV;
            op_next    = OP_LOAD_COL;
            step_next  = '0;
        end
        else
        begin
            case (state_reg)
                ST_DIV:
                begin
                    if (n_zero)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (step_reg == '0)
                    begin
                        div_num_next = op_num;
                        div_den_next = op_den;
                        div_rem_next = '0;
                        step_next    = STEP_W'(1);
                    end
                    else
                    begin
                        div_num_next = num_step;
                        div_rem_next = rem_wide[DIM_W-1:0];
                        if (step_reg == DIV_STEPS)
                        begin
                            case (op_reg)
                                OP_LOAD_COL:
                                begin
                                    lc_q_next  = num_step[POS_W-1:0];
                                    lc_ph_next = rem_wide[POS_W-1:0];
                                end
                                OP_LOAD_ROW:
                                begin
                                    lr_q_next  = num_step[POS_W-1:0];
                                    lr_ph_next = rem_wide[POS_W-1:0];
                                end
                                OP_TILE_W: tile_w_next = num_step[DIM_W-1:0];
                                OP_TILE_H: tile_h_next = num_step[DIM_W-1:0];
                                OP_OUT_COL: oc_ph_next = rem_wide[POS_W-1:0];
                                OP_OUT_ROW: or_ph_next = rem_wide[POS_W-1:0];
                                default: ;
                            endcase
                            step_next = '0;
                            if (op_reg == OP_OUT_ROW)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                op_next = op_reg + OP_W'(1);
                            end
                        end
                        else
                        begin
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                end
                ST_RUN:
                begin
                    if (in_fire && (req_type == REQ_LOAD))
                    begin
                        mem_we = !n_zero && (lc_ph_reg == '0) && (lr_ph_reg == '0);
                        if (lcol_inc >= w_eff)
                        begin
                            load_col_next = '0;
                            lc_ph_next    = '0;
                            lc_q_next     = '0;
                            if (lrow_inc >= h_eff)
                            begin
                                load_row_next = '0;
                                lr_ph_next    = '0;
                                lr_q_next     = '0;
                            end
                            else
                            begin
                                load_row_next = lrow_inc[POS_W-1:0];
                                if (lr_ph_inc == tile_count_reg)
                                begin
                                    lr_ph_next = '0;
                                    lr_q_next  = lr_q_reg + POS_W'(1);
                                end
                                else
                                begin
                                    lr_ph_next = lr_ph_inc[POS_W-1:0];
                                end
                            end
                        end
                        else
                        begin
                            load_col_next = lcol_inc[POS_W-1:0];
                            if (lc_ph_inc == tile_count_reg)
                            begin
                                lc_ph_next = '0;
                                lc_q_next  = lc_q_reg + POS_W'(1);
                            end
                            else
                            begin
                                lc_ph_next = lc_ph_inc[POS_W-1:0];
                            end
                        end
                    end
                    else if (in_fire && (req_type == REQ_EMIT))
                    begin
                        out_valid_next = 1'b1;
                        if (n_zero)
                        begin
                            bad_next  = 1'b1;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            bad_next  = 1'b0;
                            last_next = 1'b0;
                            if (ocol_inc >= w_eff)
                            begin
                                out_col_next = '0;
                                oc_ph_next   = '0;
                                if (orow_inc >= h_eff)
                                begin
                                    out_row_next = '0;
                                    or_ph_next   = '0;
                                    last_next    = 1'b1;
                                end
                                else
                                begin
                                    out_row_next = orow_inc[POS_W-1:0];
                                    or_ph_next   = (or_ph_inc == tile_h_reg) ? '0 :
                                                   or_ph_inc[POS_W-1:0];
                                end
                            end
                            else
                            begin
                                out_col_next = ocol_inc[POS_W-1:0];
                                oc_ph_next   = (oc_ph_inc == tile_w_reg) ? '0 :
                                               oc_ph_inc[POS_W-1:0];
                            end
                        end
                    end
                end
                default:
                begin
                    state_next = ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_count_reg   <= DIM_W'(1);
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TILE_COUNT:   tile_count_reg   <= cfg_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            op_reg        <= OP_LOAD_COL;
            step_reg      <= '0;
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            lc_ph_reg     <= '0;
            lc_q_reg      <= '0;
            lr_ph_reg     <= '0;
            lr_q_reg      <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            oc_ph_reg     <= '0;
            or_ph_reg     <= '0;
            tile_w_reg    <= DIM_W'(1);
            tile_h_reg    <= DIM_W'(1);
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            load_col_reg  <= load_col_next;
            load_row_reg  <= load_row_next;
            lc_ph_reg     <= lc_ph_next;
            lc_q_reg      <= lc_q_next;
            lr_ph_reg     <= lr_ph_next;
            lr_q_reg      <= lr_q_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            oc_ph_reg     <= oc_ph_next;
            or_ph_reg     <= or_ph_next;
            tile_w_reg    <= tile_w_next;
            tile_h_reg    <= tile_h_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_waddr] <= pixel_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= sample_mem[mem_raddr];
        end
    end

    `ITR_ASSERT_NEXT(a_cfg_stalls, cfg_we, in_stall, "input not held after config write")
    `ITR_ASSERT_NOW(a_load_phase, (state_reg == ST_RUN) && !n_zero,
        ({1'b0, lc_ph_reg} < tile_count_reg) && ({1'b0, lr_ph_reg} < tile_count_reg),
        "load phase out of range")
    `ITR_ASSERT_NOW(a_out_phase, (state_reg == ST_RUN) && !n_zero,
        ({1'b0, oc_ph_reg} < tile_w_reg) && ({1'b0, or_ph_reg} < tile_h_reg),
        "output phase out of range")
    `ITR_ASSERT_NEXT(a_emit_bad, in_fire && (req_type == REQ_EMIT) && n_zero,
        out_valid && bad_config && (pixel_out == '0) && !last_pixel,
        "bad config result malformed")
    `ITR_ASSERT_NEXT(a_emit_good, in_fire && (req_type == REQ_EMIT) && !n_zero,
        out_valid && !bad_config, "emit result missing")

endmodule

`default_nettype wire
